// ===== src/ecnv_pkg.sv =====
// ----------------------------------------------------------------------------
// ecnv_pkg
// Shared types, codes and defaults of the normalized-border convolution block.
// ----------------------------------------------------------------------------
package ecnv_pkg;

   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 64;
   localparam int DEF_MAX_KERNEL = 5;

   // depth of the queue between front and back, a power of two
   localparam int QUEUE_DEPTH = 4;

   localparam logic [1:0] REQ_LOAD_WEIGHT = 2'd0;
   localparam logic [1:0] REQ_LOAD_PIXEL  = 2'd1;
   localparam logic [1:0] REQ_COMPUTE     = 2'd2;

   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_KERNEL_SIZE  = 2'd2;
   localparam logic [1:0] CSR_KERNEL_MODE  = 2'd3;

   localparam logic [6:0] RST_IMAGE_WIDTH  = 7'd64;
   localparam logic [6:0] RST_IMAGE_HEIGHT = 7'd64;
   localparam logic [2:0] RST_KERNEL_SIZE  = 3'd3;
   localparam logic       RST_KERNEL_MODE  = 1'b0;

   localparam longint OUT_MAX = 64'sd8388607;
   localparam longint OUT_MIN = -64'sd8388608;

   typedef enum logic [1:0] {
      OP_WEIGHT,
      OP_PIXEL,
      OP_QUERY
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [5:0]         pos_x;
      logic [5:0]         pos_y;
      logic [4:0]         coef_index;
      logic signed [15:0] coef_value;
      logic [7:0]         pixel_value;
   } item_type;

   typedef struct packed {
      logic [6:0] image_width;
      logic [6:0] image_height;
      logic [2:0] kernel_size;
      logic       kernel_mode;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_TAP,
      BK_MAC,
      BK_FIN,
      BK_DIV,
      BK_OUT
   } back_state_type;

endpackage

// ===== src/edge_normalized_convolution.sv =====
// ----------------------------------------------------------------------------
// edge_normalized_convolution
// Order: a load is written when the back end pops it from the queue while idle;
//   a query walks its taps, then in normalized mode runs the bit-serial
//   divider, before its result word is offered.
// Throughput: one word a cycle into the queue while it has room; the back end
//   serves one operation at a time, each tap a BK_TAP store read, then BK_MAC.
// Reset: synchronous, clears control state and restores the registers; the
//   frame and weight stores are not cleared and hold garbage until loaded.
// ----------------------------------------------------------------------------
module edge_normalized_convolution #(
   parameter int MAX_WIDTH  = ecnv_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = ecnv_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_KERNEL = ecnv_pkg::DEF_MAX_KERNEL
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // pos_x[5:0], pos_y[11:6], coef_index[16:12], coef_value[32:17],
   // pixel_value[40:33], zero fill above
   input  logic [47:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]  req_tuser,
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // intensity[23:0]
   output logic [23:0] rsp_tdata,
   // zero_divisor[0], saturated[1]
   output logic [1:0]  rsp_tuser,
   // configuration write port
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_wdata
);

   ecnv_pkg::cfg_type          cfg_ff, cfg_in;
   ecnv_pkg::queue_status_type q_status;
   ecnv_pkg::item_type         push_item, pop_item;
   logic                       q_push, q_pop;

   // Register writes are to land only while the block is idle; the block does not
   // enforce it. The back end samples them at each query's start without shadowing.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            ecnv_pkg::CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_wdata;
            ecnv_pkg::CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_wdata;
            ecnv_pkg::CSR_KERNEL_SIZE:  cfg_in.kernel_size  = csr_wdata[2:0];
            ecnv_pkg::CSR_KERNEL_MODE:  cfg_in.kernel_mode  = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= ecnv_pkg::RST_IMAGE_WIDTH;
         cfg_ff.image_height <= ecnv_pkg::RST_IMAGE_HEIGHT;
         cfg_ff.kernel_size  <= ecnv_pkg::RST_KERNEL_SIZE;
         cfg_ff.kernel_mode  <= ecnv_pkg::RST_KERNEL_MODE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: decode each word, drop unused requests and out-of-range loads.
   ecnv_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .MAX_KERNEL(MAX_KERNEL)
   ) u_front (
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_item    (push_item)
   );

   // Queue: keep loads and queries in arrival order so a query sees every
   // load accepted before it.
   ecnv_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_item(push_item),
      .pop      (q_pop),
      .pop_item (pop_item),
      .status   (q_status)
   );

   // Back: perform loads, walk taps, divide in normalized mode, hold the result word.
   ecnv_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .MAX_KERNEL(MAX_KERNEL)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (!q_status.empty),
      .q_item    (pop_item),
      .q_pop     (q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // A zero divisor gives a clean zero, never a clipped one.
   a_zdiv_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 24'd0 && !rsp_tuser[1])
      else $error("zero divisor word carries data or saturation");

   // A saturated word sits at one of the two rails.
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == 24'h7FFFFF || rsp_tdata == 24'h800000)
      else $error("saturated word is not at a rail");

   // The queue can never be both full and empty.
   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty");

endmodule

// ===== src/ecnv_front.sv =====
// ----------------------------------------------------------------------------
// ecnv_front
// Accept request words, drop those that do nothing, classify the rest.
// ----------------------------------------------------------------------------
module ecnv_front #(
   parameter int MAX_WIDTH  = ecnv_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = ecnv_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_KERNEL = ecnv_pkg::DEF_MAX_KERNEL
) (
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [47:0]                req_tdata,
   input  logic [1:0]                 req_tuser,
   input  ecnv_pkg::queue_status_type q_status,
   output logic                       q_push,
   output ecnv_pkg::item_type         q_item
);

   logic keep;

   always_comb begin
      q_item.pos_x       = req_tdata[5:0];
      q_item.pos_y       = req_tdata[11:6];
      q_item.coef_index  = req_tdata[16:12];
      q_item.coef_value  = req_tdata[32:17];
      q_item.pixel_value = req_tdata[40:33];
      q_item.op          = ecnv_pkg::OP_QUERY;
      keep               = 1'b0;
      unique case (req_tuser)
         ecnv_pkg::REQ_LOAD_WEIGHT: begin
            q_item.op = ecnv_pkg::OP_WEIGHT;
            keep      = (int'(req_tdata[16:12]) < MAX_KERNEL * MAX_KERNEL);
         end
         ecnv_pkg::REQ_LOAD_PIXEL: begin
            q_item.op = ecnv_pkg::OP_PIXEL;
            keep      = (int'(req_tdata[5:0]) < MAX_WIDTH) &&
                        (int'(req_tdata[11:6]) < MAX_HEIGHT);
         end
         ecnv_pkg::REQ_COMPUTE: begin
            q_item.op = ecnv_pkg::OP_QUERY;
            keep      = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // take every word while the queue has room; dropped words just vanish
   assign req_tready = !q_status.full;
   assign q_push     = req_tvalid && req_tready && keep;

endmodule

// ===== src/ecnv_queue.sv =====
// ----------------------------------------------------------------------------
// ecnv_queue
// Short FIFO of classified operations between front and back.
// ----------------------------------------------------------------------------
module ecnv_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  ecnv_pkg::item_type         push_item,
   input  logic                       pop,
   output ecnv_pkg::item_type         pop_item,
   output ecnv_pkg::queue_status_type status
);

   localparam int PW = $clog2(ecnv_pkg::QUEUE_DEPTH);

   ecnv_pkg::item_type entry_ff [ecnv_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign status.full  = (count_ff == (PW+1)'(ecnv_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_item     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== src/ecnv_divider.sv =====
// ----------------------------------------------------------------------------
// ecnv_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ecnv_divider #(
   parameter int NW = 38,
   parameter int DW = 24
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] quotient
);

   localparam int CW = $clog2(NW + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dsr_ff, dsr_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;

   assign trial = {rem_ff, quo_ff[NW-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (start) begin
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
         rem_in  = '0;
         dsr_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         if (!diff[DW]) begin
            rem_in = diff[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/ecnv_back.sv =====
// ----------------------------------------------------------------------------
// ecnv_back
// Hold the stores, walk kernel taps, normalize unless in sum mode, drive the result word.
// ----------------------------------------------------------------------------
module ecnv_back #(
   parameter int MAX_WIDTH  = ecnv_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = ecnv_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_KERNEL = ecnv_pkg::DEF_MAX_KERNEL
) (
   input  logic               clock,
   input  logic               reset,
   input  ecnv_pkg::cfg_type  cfg,
   input  logic               q_valid,
   input  ecnv_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [23:0]        rsp_tdata,
   output logic [1:0]         rsp_tuser
);

   localparam int KK     = MAX_KERNEL * MAX_KERNEL;
   localparam int WIW    = (KK > 1) ? $clog2(KK) : 1;
   localparam int FDEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int FAW    = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
   localparam int KW     = $clog2(MAX_KERNEL + 1);
   localparam int TW     = $clog2(MAX_WIDTH + MAX_HEIGHT + MAX_KERNEL + 64) + 2;
   localparam int AW     = $clog2(KK * 255 * 32768) + 2;
   localparam int WSW    = $clog2(KK * 32768) + 2;
   localparam int NW     = AW + 8;

   ecnv_pkg::back_state_type state_ff, state_in;

   logic [7:0]         frame_mem [FDEPTH];
   logic signed [15:0] weight_mem [KK];

   logic [5:0]            px_ff, px_in, py_ff, py_in;
   logic [KW-1:0]         kx_ff, kx_in, ky_ff, ky_in, k_ff, k_in, c_ff, c_in;
   logic [WIW-1:0]        widx_ff, widx_in;
   logic [TW-1:0]         w_ff, w_in, h_ff, h_in;
   logic                  mode_ff, mode_in, last_ff, last_in, tap_in_ff, tap_in_in;
   logic signed [AW-1:0]  acc_ff, acc_in;
   logic signed [WSW-1:0] wsum_ff, wsum_in;
   logic                  neg_ff, neg_in, zdiv_ff, zdiv_in;
   logic signed [NW:0]    res_ff, res_in;
   logic                  out_valid_ff, out_valid_in;
   logic [23:0]           out_data_ff, out_data_in;
   logic                  out_zdiv_ff, out_zdiv_in, out_sat_ff, out_sat_in;

   logic [7:0]            pix_rd_ff;
   logic signed [15:0]    wt_rd_ff;
   logic                  fr_we, wt_we, rd_en;
   logic [FAW-1:0]        fr_wa, fr_ra;
   logic [WIW-1:0]        wt_wa;
   logic [TW-1:0]         ty, tx;
   logic                  tap_hit;
   logic [KW-1:0]         k_clamp;
   logic [KW:0]           kp1;
   logic signed [24:0]    prod;
   logic [AW-1:0]         acc_abs;
   logic [WSW-1:0]        wsum_abs;
   logic                  div_start, div_done;
   logic [NW-1:0]         div_quotient;
   logic                  over, under;

   assign fr_wa = FAW'(int'(q_item.pos_y) * MAX_WIDTH + int'(q_item.pos_x));
   assign wt_wa = WIW'(q_item.coef_index);
   assign ty    = TW'(py_ff) + TW'(ky_ff) - TW'(c_ff);
   assign tx    = TW'(px_ff) + TW'(kx_ff) - TW'(c_ff);
   assign tap_hit = !ty[TW-1] && (ty < h_ff) && !tx[TW-1] && (tx < w_ff);
   assign fr_ra = FAW'(ty * MAX_WIDTH + tx);
   assign prod  = $signed({1'b0, pix_rd_ff}) * wt_rd_ff;
   assign acc_abs  = acc_ff[AW-1] ? AW'(-acc_ff) : AW'(acc_ff);
   assign wsum_abs = wsum_ff[WSW-1] ? WSW'(-wsum_ff) : WSW'(wsum_ff);
   assign over  = (res_ff > $signed((NW+1)'(ecnv_pkg::OUT_MAX)));
   assign under = (res_ff < $signed((NW+1)'(ecnv_pkg::OUT_MIN)));

   always_comb begin
      if (cfg.kernel_size == '0) begin
         k_clamp = KW'(1);
      end else if (int'(cfg.kernel_size) > MAX_KERNEL) begin
         k_clamp = KW'(MAX_KERNEL);
      end else begin
         k_clamp = KW'(cfg.kernel_size);
      end
      kp1 = {1'b0, k_clamp} + (KW+1)'(1);
   end

   always_comb begin
      state_in     = state_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      kx_in        = kx_ff;
      ky_in        = ky_ff;
      k_in         = k_ff;
      c_in         = c_ff;
      widx_in      = widx_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      mode_in      = mode_ff;
      last_in      = last_ff;
      tap_in_in    = tap_in_ff;
      acc_in       = acc_ff;
      wsum_in      = wsum_ff;
      neg_in       = neg_ff;
      zdiv_in      = zdiv_ff;
      res_in       = res_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_zdiv_in  = out_zdiv_ff;
      out_sat_in   = out_sat_ff;
      q_pop        = 1'b0;
      fr_we        = 1'b0;
      wt_we        = 1'b0;
      rd_en        = 1'b0;
      div_start    = 1'b0;
      unique case (state_ff)
         ecnv_pkg::BK_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               unique case (q_item.op)
                  ecnv_pkg::OP_WEIGHT: wt_we = 1'b1;
                  ecnv_pkg::OP_PIXEL:  fr_we = 1'b1;
                  ecnv_pkg::OP_QUERY: begin
                     px_in   = q_item.pos_x;
                     py_in   = q_item.pos_y;
                     kx_in   = '0;
                     ky_in   = '0;
                     widx_in = '0;
                     k_in    = k_clamp;
                     c_in    = KW'((kp1 >> 1) - (KW+1)'(1));
                     mode_in = cfg.kernel_mode;
                     acc_in  = '0;
                     wsum_in = '0;
                     if (cfg.image_width == '0) begin
                        w_in = TW'(1);
                     end else if (int'(cfg.image_width) > MAX_WIDTH) begin
                        w_in = TW'(MAX_WIDTH);
                     end else begin
                        w_in = TW'(cfg.image_width);
                     end
                     if (cfg.image_height == '0) begin
                        h_in = TW'(1);
                     end else if (int'(cfg.image_height) > MAX_HEIGHT) begin
                        h_in = TW'(MAX_HEIGHT);
                     end else begin
                        h_in = TW'(cfg.image_height);
                     end
                     state_in = ecnv_pkg::BK_TAP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ecnv_pkg::BK_TAP: begin
            rd_en     = 1'b1;
            tap_in_in = tap_hit;
            last_in   = (kx_ff == k_ff - 1'b1) && (ky_ff == k_ff - 1'b1);
            widx_in   = widx_ff + 1'b1;
            if (kx_ff == k_ff - 1'b1) begin
               kx_in = '0;
               ky_in = ky_ff + 1'b1;
            end else begin
               kx_in = kx_ff + 1'b1;
            end
            state_in = ecnv_pkg::BK_MAC;
         end
         ecnv_pkg::BK_MAC: begin
            if (tap_in_ff) begin
               acc_in  = acc_ff + AW'(prod);
               wsum_in = wsum_ff + WSW'(wt_rd_ff);
            end
            state_in = last_ff ? ecnv_pkg::BK_FIN : ecnv_pkg::BK_TAP;
         end
         ecnv_pkg::BK_FIN: begin
            zdiv_in = 1'b0;
            if (mode_ff) begin
               res_in   = (NW+1)'(acc_ff);
               state_in = ecnv_pkg::BK_OUT;
            end else if (wsum_ff == '0) begin
               res_in   = '0;
               zdiv_in  = 1'b1;
               state_in = ecnv_pkg::BK_OUT;
            end else begin
               neg_in    = acc_ff[AW-1] ^ wsum_ff[WSW-1];
               div_start = 1'b1;
               state_in  = ecnv_pkg::BK_DIV;
            end
         end
         ecnv_pkg::BK_DIV: begin
            if (div_done) begin
               res_in   = neg_ff ? -$signed({1'b0, div_quotient})
                                 : $signed({1'b0, div_quotient});
               state_in = ecnv_pkg::BK_OUT;
            end
         end
         ecnv_pkg::BK_OUT: begin
            // load the output register once the old word has left
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_zdiv_in  = zdiv_ff;
               out_sat_in   = over || under;
               if (over) begin
                  out_data_in = 24'h7FFFFF;
               end else if (under) begin
                  out_data_in = 24'h800000;
               end else begin
                  out_data_in = res_ff[23:0];
               end
               state_in = ecnv_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = ecnv_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ecnv_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      py_ff       <= py_in;
      kx_ff       <= kx_in;
      ky_ff       <= ky_in;
      k_ff        <= k_in;
      c_ff        <= c_in;
      widx_ff     <= widx_in;
      w_ff        <= w_in;
      h_ff        <= h_in;
      mode_ff     <= mode_in;
      last_ff     <= last_in;
      tap_in_ff   <= tap_in_in;
      acc_ff      <= acc_in;
      wsum_ff     <= wsum_in;
      neg_ff      <= neg_in;
      zdiv_ff     <= zdiv_in;
      res_ff      <= res_in;
      out_data_ff <= out_data_in;
      out_zdiv_ff <= out_zdiv_in;
      out_sat_ff  <= out_sat_in;
   end

   always_ff @(posedge clock) begin
      if (fr_we) begin
         frame_mem[fr_wa] <= q_item.pixel_value;
      end
      if (rd_en) begin
         pix_rd_ff <= frame_mem[fr_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (wt_we) begin
         weight_mem[wt_wa] <= q_item.coef_value;
      end
      if (rd_en) begin
         wt_rd_ff <= weight_mem[widx_ff];
      end
   end

   ecnv_divider #(
      .NW(NW),
      .DW(WSW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({acc_abs, 8'd0}),
      .divisor  (wsum_abs),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = {out_sat_ff, out_zdiv_ff};

endmodule
